@@ rtl/gbt_pkg.sv @@
// shared types, widths and codes of the gap buffer text store
package gbt_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_RAM_WIDTH = 8;

    localparam int OP_W = 3;
    localparam int CHAR_W = 8;
    localparam int CNT_W = 11;
    localparam int POS_W = 10;
    localparam int ST_W = 2;
    localparam int LEN_W = 11;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_FWD = 3'd2;
    localparam logic [OP_W-1:0] OP_BACK = 3'd3;
    localparam logic [OP_W-1:0] OP_READ = 3'd4;

    localparam logic [ST_W-1:0] ST_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [CHAR_W-1:0] char_in;
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] position;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [CHAR_W-1:0] char_out;
        logic [LEN_W-1:0] text_length;
        logic [LEN_W-1:0] cursor;
    } res_t;

endpackage

@@ rtl/gbt_if.sv @@
// command and response channel interfaces
interface gbt_cmd_if import gbt_pkg::*; ();
    logic valid;
    logic ready;
    logic [OP_W-1:0] operation;
    logic [CHAR_W-1:0] char_in;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] position;

    modport source (output valid, output operation, output char_in, output count,
                    output position, input ready);
    modport sink (input valid, input operation, input char_in, input count,
                  input position, output ready);
endinterface

interface gbt_rsp_if import gbt_pkg::*; ();
    logic valid;
    logic ready;
    logic [ST_W-1:0] status;
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0] text_length;
    logic [LEN_W-1:0] cursor;

    modport source (output valid, output status, output char_out, output text_length,
                    output cursor, input ready);
    modport sink (input valid, input status, input char_out, input text_length,
                  input cursor, output ready);
endinterface

@@ rtl/gbt_ram.sv @@
// generic single write, single read ram with registered read data
module gbt_ram import gbt_pkg::*; #(
    parameter int WIDTH = DEF_RAM_WIDTH,
    parameter int DEPTH = DEF_CAPACITY
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/gbt_ctrl.sv @@
// command sequencer: gap pointers, copy engine and text ram
module gbt_ctrl import gbt_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd_data,
    output logic res_valid,
    input  logic res_ready,
    output res_t res_data
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (PW > LEN_W) ? PW : LEN_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_COPY  = 5'b00100,
        S_RWAIT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    logic [PW-1:0] gs_reg, gs_next;
    logic [PW-1:0] ge_reg, ge_next;
    logic [PW-1:0] len_reg, len_next;
    logic fwd_reg, fwd_next;
    logic pend_reg, pend_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [ST_W-1:0] status_reg, status_next;
    logic [CHAR_W-1:0] char_reg, char_next;

    logic ram_wen;
    logic [AW-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic ram_ren;
    logic [AW-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic [XW-1:0] gs_x;
    logic [XW-1:0] len_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] right_x;
    logic [XW-1:0] rd_off;
    logic [PW-1:0] cnt_p;
    logic [AW-1:0] read_addr;

    gbt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign gs_x = XW'(gs_reg);
    assign len_x = XW'(len_reg);
    assign cnt_x = XW'(cmd_reg.count);
    assign pos_x = XW'(cmd_reg.position);
    assign right_x = XW'(PW'(CAPACITY) - ge_reg);
    assign rd_off = XW'(ge_reg - gs_reg) + pos_x;
    assign cnt_p = PW'(cmd_reg.count);
    assign read_addr = (pos_x < gs_x) ? pos_x[AW-1:0] : rd_off[AW-1:0];

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res_data.status = status_reg;
    assign res_data.char_out = char_reg;
    assign res_data.text_length = len_x[LEN_W-1:0];
    assign res_data.cursor = gs_x[LEN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        gs_next = gs_reg;
        ge_next = ge_reg;
        len_next = len_reg;
        fwd_next = fwd_reg;
        pend_next = pend_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        remain_next = remain_reg;
        status_next = status_reg;
        char_next = char_reg;
        ram_wen = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_ren = 1'b0;
        ram_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd_data;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                status_next = ST_OK;
                char_next = '0;
                state_next = S_DONE;
                case (cmd_reg.operation)
                    OP_INSERT:
                    begin
                        if (gs_reg == ge_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_wen = 1'b1;
                            ram_waddr = gs_reg[AW-1:0];
                            ram_wdata = cmd_reg.char_in;
                            gs_next = gs_reg + PW'(1);
                            len_next = len_reg + PW'(1);
                        end
                    end
                    OP_DELETE:
                    begin
                        if (cnt_x > gs_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            gs_next = gs_reg - cnt_p;
                            len_next = len_reg - cnt_p;
                        end
                    end
                    OP_FWD:
                    begin
                        if (cnt_x > right_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            src_next = ge_reg[AW-1:0];
                            dst_next = gs_reg[AW-1:0];
                            remain_next = cmd_reg.count;
                            pend_next = 1'b0;
                            fwd_next = 1'b1;
                            state_next = S_COPY;
                        end
                    end
                    OP_BACK:
                    begin
                        if (cnt_x > gs_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            src_next = gs_reg[AW-1:0] - AW'(1);
                            dst_next = ge_reg[AW-1:0] - AW'(1);
                            remain_next = cmd_reg.count;
                            pend_next = 1'b0;
                            fwd_next = 1'b0;
                            state_next = S_COPY;
                        end
                    end
                    OP_READ:
                    begin
                        if (pos_x >= len_x)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            ram_ren = 1'b1;
                            ram_raddr = read_addr;
                            state_next = S_RWAIT;
                        end
                    end
                    default:
                    begin
                        status_next = ST_RANGE;
                    end
                endcase
            end
            S_COPY:
            begin
                // reads run one entry ahead of the writes
                pend_next = (remain_reg != '0);
                if (remain_reg != '0)
                begin
                    ram_ren = 1'b1;
                    ram_raddr = src_reg;
                    src_next = fwd_reg ? (src_reg + AW'(1)) : (src_reg - AW'(1));
                    remain_next = remain_reg - CNT_W'(1);
                end
                if (pend_reg)
                begin
                    ram_wen = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                    dst_next = fwd_reg ? (dst_reg + AW'(1)) : (dst_reg - AW'(1));
                end
                if (remain_reg == '0)
                begin
                    state_next = S_DONE;
                    if (fwd_reg)
                    begin
                        gs_next = gs_reg + cnt_p;
                        ge_next = ge_reg + cnt_p;
                    end
                    else
                    begin
                        gs_next = gs_reg - cnt_p;
                        ge_next = ge_reg - cnt_p;
                    end
                end
            end
            S_RWAIT:
            begin
                char_next = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gs_reg <= '0;
            ge_reg <= PW'(CAPACITY);
            len_reg <= '0;
            pend_reg <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            gs_reg <= gs_next;
            ge_reg <= ge_next;
            len_reg <= len_next;
            pend_reg <= pend_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        fwd_reg <= fwd_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        status_reg <= status_next;
        char_reg <= char_next;
    end

endmodule

@@ rtl/gap_buffer_text_store.sv @@
// gap buffer text store top level with response output register
//
// one command transfer on cmd (operation, char_in, count, position) gives
// exactly one response transfer on rsp (status, char_out, text_length, cursor).
// commands are handled one at a time by a sequencer around a single text ram
// of CAPACITY bytes with one write and one registered read port.
// sequencer states passed between one command transfer and the next accepted one:
//   insert, delete, bad code, range or full error: check, then done
//   read: check, a ram read wait, then done
//   move forward or back by count bytes: check, copy, then done; the copy moves
//   one byte per cycle through the ram, reads running one entry ahead of writes
// the response enters the output register from the done state, once that
// register is free or being emptied.
// while a response waits in the output register the next command is taken
// and processed; it is held inside only once its own response is ready and
// the register is still full.
// reset empties the text: cursor and length go to zero. the ram is not
// cleared; only written positions are ever read back.
module gap_buffer_text_store import gbt_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    gbt_cmd_if.sink cmd,
    gbt_rsp_if.source rsp
);

    cmd_t cmd_data;
    res_t res_data;
    res_t out_data_reg;
    logic out_valid_reg;
    logic res_valid;
    logic res_take;

    assign cmd_data.operation = cmd.operation;
    assign cmd_data.char_in = cmd.char_in;
    assign cmd_data.count = cmd.count;
    assign cmd_data.position = cmd.position;

    gbt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_take),
        .res_data  (res_data)
    );

    assign res_take = res_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res_data;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_data_reg.status;
    assign rsp.char_out = out_data_reg.char_out;
    assign rsp.text_length = out_data_reg.text_length;
    assign rsp.cursor = out_data_reg.cursor;

    // one command in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command taken while another is in flight");

    // a finished result always lands in the output register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> rsp.valid)
        else $error("result lost on its way to the output register");

    // only a successful read returns a byte
    a_char_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.char_out == '0)
        else $error("byte returned with an error status");

    // the cursor never lies beyond the text end
    a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (CAPACITY < 2048) |-> rsp.cursor <= rsp.text_length)
        else $error("cursor beyond text length");

endmodule
